/* design/hrfe_pkg.sv */
`timescale 1ns / 1ps

package hrfe_pkg;

  // Longest method that is passed on; later method bytes only set the flag.
  localparam int METHOD_MAX = 9;
  localparam int METHOD_LEN_W = $clog2(METHOD_MAX + 1);

  // Width of the internal body counter and of the reported count.
  localparam int COUNT_BITS = 32;
  localparam int BODY_W = 32;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] HOST_WORD [4] = '{8'h48, 8'h4F, 8'h53, 8'h54};
  localparam logic [2:0] HOST_LEN = 3'd4;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_TARGET  = 3'd1;
  localparam logic [2:0] KIND_HOST    = 3'd2;
  localparam logic [2:0] KIND_PORT    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_SEEK,
    PH_TARGET,
    PH_LINE_REST,
    PH_NAME,
    PH_LETTER,
    PH_HOST,
    PH_PORT,
    PH_SKIP,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        field_kind;
    logic [7:0]        data_byte;
    logic [BODY_W-1:0] body_count;
    logic [7:0]        body_parity;
    logic              port_defaulted;
    logic              host_seen;
    logic              method_truncated;
    logic              run_end;
  } out_item_t;

  // Results produced by one input byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } step_res_t;

  function automatic out_item_t make_data(input logic [2:0] kind, input logic [7:0] data);
    out_item_t r;
    r = '0;
    r.field_kind = kind;
    r.data_byte = data;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
  endfunction

endpackage

/* design/hrfe_parser.sv */
`timescale 1ns / 1ps

module hrfe_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  hrfe_pkg::in_item_t  item,
  output hrfe_pkg::step_res_t res
);
  import hrfe_pkg::*;

  phase_t                  phase, phase_next;
  logic [2:0]              name_idx, name_idx_next;
  logic [7:0]              prev_byte, prev_byte_next;
  logic                    slash_pending, slash_pending_next;
  logic [METHOD_LEN_W-1:0] method_len, method_len_next;
  logic                    host_found, host_found_next;
  logic                    port_found, port_found_next;
  logic                    trunc, trunc_next;
  logic [COUNT_BITS-1:0]   byte_count, byte_count_next;
  logic [7:0]              xor_acc, xor_acc_next;

  out_item_t  res_n [2];
  logic [1:0] cnt;
  logic [7:0] b;
  logic       eos;
  out_item_t  summ;

  assign b = item.in_byte;
  assign eos = item.end_of_stream;

  always_comb begin
    phase_next = phase;
    name_idx_next = name_idx;
    slash_pending_next = slash_pending;
    method_len_next = method_len;
    host_found_next = host_found;
    port_found_next = port_found;
    trunc_next = trunc;
    byte_count_next = byte_count;
    xor_acc_next = xor_acc;
    res_n[0] = '0;
    res_n[1] = '0;
    cnt = 2'd0;
    summ = '0;

    case (phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          phase_next = PH_SEEK;
        end else if (b == CH_LF) begin
          phase_next = PH_NAME;
          name_idx_next = 3'd0;
        end else if (method_len < METHOD_LEN_W'(METHOD_MAX)) begin
          res_n[cnt[0]] = make_data(KIND_METHOD, b);
          cnt = cnt + 2'd1;
          method_len_next = method_len + METHOD_LEN_W'(1);
        end else begin
          trunc_next = 1'b1;
        end
      end
      PH_SEEK: begin
        if (slash_pending) begin
          slash_pending_next = 1'b0;
          // A slash is a target start only when the byte after it is not a slash.
          if (b != CH_SLASH) begin
            res_n[cnt[0]] = make_data(KIND_TARGET, CH_SLASH);
            cnt = cnt + 2'd1;
            if (b == CH_SP) begin
              phase_next = PH_LINE_REST;
            end else if (b == CH_LF) begin
              phase_next = PH_NAME;
              name_idx_next = 3'd0;
            end else begin
              if (!eos) begin
                res_n[cnt[0]] = make_data(KIND_TARGET, b);
                cnt = cnt + 2'd1;
              end
              phase_next = PH_TARGET;
            end
          end
        end else if (b == CH_SLASH && prev_byte != CH_SLASH) begin
          slash_pending_next = 1'b1;
        end else if (b == CH_LF) begin
          phase_next = PH_NAME;
          name_idx_next = 3'd0;
        end
      end
      PH_TARGET: begin
        if (b == CH_SP) begin
          phase_next = PH_LINE_REST;
        end else if (b == CH_LF) begin
          phase_next = PH_NAME;
          name_idx_next = 3'd0;
        end else begin
          res_n[cnt[0]] = make_data(KIND_TARGET, b);
          cnt = cnt + 2'd1;
        end
      end
      PH_LINE_REST, PH_SKIP: begin
        if (b == CH_LF) begin
          phase_next = PH_NAME;
          name_idx_next = 3'd0;
        end
      end
      PH_NAME: begin
        if (b == CH_LF) begin
          // An empty line ends the headers.
          if (name_idx == 3'd0) begin
            phase_next = PH_BODY;
          end
          name_idx_next = 3'd0;
        end else if (host_found) begin
          phase_next = PH_SKIP;
        end else if (name_idx < HOST_LEN && to_upper(b) == HOST_WORD[name_idx[1:0]]) begin
          if (name_idx + 3'd1 == HOST_LEN) begin
            host_found_next = 1'b1;
            name_idx_next = 3'd0;
            phase_next = PH_LETTER;
          end else begin
            name_idx_next = name_idx + 3'd1;
          end
        end else begin
          name_idx_next = 3'd0;
          phase_next = PH_SKIP;
        end
      end
      PH_LETTER: begin
        if (b == CH_LF) begin
          phase_next = PH_NAME;
        end else if (is_alpha(b)) begin
          res_n[cnt[0]] = make_data(KIND_HOST, b);
          cnt = cnt + 2'd1;
          phase_next = PH_HOST;
        end
      end
      PH_HOST: begin
        if (b == CH_LF) begin
          phase_next = PH_NAME;
        end else if (b == CH_COLON) begin
          port_found_next = 1'b1;
          phase_next = PH_PORT;
        end else begin
          res_n[cnt[0]] = make_data(KIND_HOST, b);
          cnt = cnt + 2'd1;
        end
      end
      PH_PORT: begin
        if (b == CH_LF) begin
          phase_next = PH_NAME;
        end else begin
          res_n[cnt[0]] = make_data(KIND_PORT, b);
          cnt = cnt + 2'd1;
        end
      end
      default: begin
        if (byte_count != '1) begin
          byte_count_next = byte_count + COUNT_BITS'(1);
        end
        xor_acc_next = xor_acc ^ b;
        phase_next = PH_BODY;
      end
    endcase
    prev_byte_next = b;

    if (eos) begin
      summ.field_kind = KIND_SUMMARY;
      summ.body_count = (COUNT_BITS > BODY_W && (byte_count_next >> BODY_W) != '0) ?
                        '1 : BODY_W'(byte_count_next);
      summ.body_parity = xor_acc_next;
      summ.port_defaulted = !port_found_next;
      summ.host_seen = host_found_next;
      summ.method_truncated = trunc_next;
      res_n[cnt[0]] = summ;
      cnt = cnt + 2'd1;
      // The next byte starts a fresh request.
      phase_next = PH_METHOD;
      name_idx_next = 3'd0;
      prev_byte_next = CH_SP;
      slash_pending_next = 1'b0;
      method_len_next = '0;
      host_found_next = 1'b0;
      port_found_next = 1'b0;
      trunc_next = 1'b0;
      byte_count_next = '0;
      xor_acc_next = 8'd0;
    end

    if (cnt == 2'd1) begin
      res_n[0].run_end = 1'b1;
    end else if (cnt == 2'd2) begin
      res_n[1].run_end = 1'b1;
    end
  end

  assign res.count = cnt;
  assign res.first = res_n[0];
  assign res.second = res_n[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD;
      name_idx <= 3'd0;
      prev_byte <= CH_SP;
      slash_pending <= 1'b0;
      method_len <= '0;
      host_found <= 1'b0;
      port_found <= 1'b0;
      trunc <= 1'b0;
      byte_count <= '0;
      xor_acc <= 8'd0;
    end else if (step) begin
      phase <= phase_next;
      name_idx <= name_idx_next;
      prev_byte <= prev_byte_next;
      slash_pending <= slash_pending_next;
      method_len <= method_len_next;
      host_found <= host_found_next;
      port_found <= port_found_next;
      trunc <= trunc_next;
      byte_count <= byte_count_next;
      xor_acc <= xor_acc_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) res.count != 2'd3)
    else $error("parser produced more than two results");
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    res.count == 2'd2 |-> res.first.field_kind != KIND_SUMMARY)
    else $error("summary is not the last result of its byte");
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    step && eos |=> phase == PH_METHOD && byte_count == '0 && !host_found)
    else $error("end of stream did not clear the parser state");
`endif

endmodule

/* design/hrfe_out_stage.sv */
`timescale 1ns / 1ps

module hrfe_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hrfe_pkg::step_res_t  res,
  output logic                 room,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hrfe_pkg::out_item_t  res_item
);
  import hrfe_pkg::*;

  logic      v0, v1;
  out_item_t d0, d1;
  logic      pop;

  assign pop = v0 && res_ready;
  // Both slots are free by the next edge.
  assign room = !v0 || (pop && !v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (load) begin
      v0 <= 1'b1;
      v1 <= (res.count == 2'd2);
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d0 <= res.first;
      d1 <= res.second;
    end else if (pop) begin
      d0 <= d1;
    end
  end

  assign res_valid = v0;
  assign res_item = d0;

`ifndef SYNTHESIS
  a_slot_order: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("second slot holds a result while the first is empty");
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> room && res.count != 2'd0)
    else $error("results loaded without room or without content");
`endif

endmodule

/* design/http_request_field_extractor.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     in_item   (in_byte, end_of_stream)
// output    res_valid / res_ready   res_item  (one extracted byte or the summary)
//
// A request byte is taken into an input register, parsed there combinationally and its
// zero to two results land in a two-slot output register.
// Sustained rate is one byte per cycle while res_ready stays high; after a byte that yields
// two results, the next byte waits in the input register while the output slots drain.
// Reset is synchronous and returns the parser to the start of a request.
// A stalled output stops loads once slot 0 holds a result, then the input register fills, then in_ready drops.
module http_request_field_extractor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hrfe_pkg::in_item_t  in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output hrfe_pkg::out_item_t res_item
);
  import hrfe_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  step_res_t step_res;
  logic      room;
  logic      advance;

  assign advance = s1_valid && (step_res.count == 2'd0 || room);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  hrfe_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (step_res)
  );

  hrfe_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step_res.count != 2'd0),
    .res       (step_res),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
